/* sv/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// When pre holds, post must hold at the following clock edge.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

/* sv/fv_heat_pkg.sv */
`timescale 1ns / 1ps

package fv_heat_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_CELL_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_TIME_STEP   = 3'd1;
   localparam logic [2:0] CSR_LEFT_KIND   = 3'd2;
   localparam logic [2:0] CSR_LEFT_VALUE  = 3'd3;
   localparam logic [2:0] CSR_LEFT_COEFF  = 3'd4;
   localparam logic [2:0] CSR_RIGHT_KIND  = 3'd5;
   localparam logic [2:0] CSR_RIGHT_VALUE = 3'd6;
   localparam logic [2:0] CSR_RIGHT_COEFF = 3'd7;

   // Boundary kinds
   localparam logic [1:0] KIND_TEMP = 2'd0;
   localparam logic [1:0] KIND_FLUX = 2'd1;
   localparam logic [1:0] KIND_CONV = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   // Mesh position codes
   localparam logic [1:0] CS_START = 2'd0;
   localparam logic [1:0] CS_FIRST = 2'd1;
   localparam logic [1:0] CS_INNER = 2'd2;
   localparam logic [1:0] CS_SPARE = 2'd3;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // Microcode entry points
   localparam logic [5:0] PC_MID    = 6'd0;
   localparam logic [5:0] PC_EDGE   = 6'd19;
   localparam logic [5:0] PC_K_TEMP = 6'd25;
   localparam logic [5:0] PC_K_FLUX = 6'd30;
   localparam logic [5:0] PC_K_NONE = 6'd33;
   localparam logic [5:0] PC_K_CONV = 6'd36;
   localparam logic [5:0] PC_COMMON = 6'd43;
   localparam logic [5:0] PC_LEFT   = 6'd48;
   localparam logic [5:0] PC_RIGHT  = 6'd51;
   localparam logic [5:0] PC_RESID  = 6'd53;
   localparam logic [5:0] PC_LAST   = 6'd57;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_EXEC = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_HARM = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_WB   = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      ROW_LEFT,
      ROW_MID,
      ROW_RIGHT
   } row_type;

   typedef enum logic [3:0] {
      OP_ADD,
      OP_SUB,
      OP_NEG,
      OP_MUL,
      OP_DIV,
      OP_HARM,
      OP_JMP,
      OP_KIND,
      OP_SIDE,
      OP_END
   } op_type;

   // Operand sources and destinations
   typedef enum logic [4:0] {
      S_ZERO, S_ONE, S_RHO, S_CP, S_KW, S_KP, S_KO, S_U0, S_UW, S_UP, S_UN,
      S_DX, S_DT, S_V, S_H, S_X, S_AP0, S_A, S_AE, S_T, S_SU, S_SP, S_D,
      S_L, S_U, S_R, S_ACC, S_RES, S_OFF
   } src_type;

   typedef struct packed {
      op_type     op;
      src_type    sa;
      src_type    sb;
      src_type    dst;
      logic [5:0] tgt;
   } instr_type;

   // Row assembly microprogram
   function automatic instr_type ucode(input logic [5:0] pc);
      instr_type i;
      i = '{OP_END, S_ZERO, S_ZERO, S_X, PC_MID};
      case (pc)
         // interior row
         6'd0:  i = '{OP_MUL,  S_RHO, S_CP,   S_X,   PC_MID};
         6'd1:  i = '{OP_MUL,  S_X,   S_DX,   S_X,   PC_MID};
         6'd2:  i = '{OP_DIV,  S_X,   S_DT,   S_AP0, PC_MID};
         6'd3:  i = '{OP_HARM, S_KW,  S_KP,   S_X,   PC_MID};
         6'd4:  i = '{OP_DIV,  S_X,   S_DX,   S_A,   PC_MID};
         6'd5:  i = '{OP_HARM, S_KP,  S_KO,   S_X,   PC_MID};
         6'd6:  i = '{OP_DIV,  S_X,   S_DX,   S_AE,  PC_MID};
         6'd7:  i = '{OP_NEG,  S_A,   S_ZERO, S_L,   PC_MID};
         6'd8:  i = '{OP_ADD,  S_AP0, S_A,    S_D,   PC_MID};
         6'd9:  i = '{OP_ADD,  S_D,   S_AE,   S_D,   PC_MID};
         6'd10: i = '{OP_NEG,  S_AE,  S_ZERO, S_U,   PC_MID};
         6'd11: i = '{OP_MUL,  S_AP0, S_U0,   S_R,   PC_MID};
         6'd12: i = '{OP_MUL,  S_L,   S_UW,   S_X,   PC_MID};
         6'd13: i = '{OP_MUL,  S_D,   S_UP,   S_ACC, PC_MID};
         6'd14: i = '{OP_ADD,  S_X,   S_ACC,  S_ACC, PC_MID};
         6'd15: i = '{OP_MUL,  S_U,   S_UN,   S_X,   PC_MID};
         6'd16: i = '{OP_ADD,  S_ACC, S_X,    S_ACC, PC_MID};
         6'd17: i = '{OP_SUB,  S_R,   S_ACC,  S_RES, PC_MID};
         6'd18: i = '{OP_END,  S_ZERO, S_ZERO, S_X,  PC_MID};
         // boundary row
         6'd19: i = '{OP_MUL,  S_RHO, S_CP,   S_X,   PC_MID};
         6'd20: i = '{OP_MUL,  S_X,   S_DX,   S_X,   PC_MID};
         6'd21: i = '{OP_DIV,  S_X,   S_DT,   S_AP0, PC_MID};
         6'd22: i = '{OP_HARM, S_KP,  S_KO,   S_X,   PC_MID};
         6'd23: i = '{OP_DIV,  S_X,   S_DX,   S_A,   PC_MID};
         6'd24: i = '{OP_KIND, S_ZERO, S_ZERO, S_X,  PC_MID};
         // prescribed temperature
         6'd25: i = '{OP_ADD,  S_KP,  S_KP,   S_T,   PC_MID};
         6'd26: i = '{OP_DIV,  S_T,   S_DX,   S_T,   PC_MID};
         6'd27: i = '{OP_MUL,  S_T,   S_V,    S_SU,  PC_MID};
         6'd28: i = '{OP_NEG,  S_T,   S_ZERO, S_SP,  PC_MID};
         6'd29: i = '{OP_JMP,  S_ZERO, S_ZERO, S_X,  PC_COMMON};
         // prescribed flux
         6'd30: i = '{OP_NEG,  S_V,   S_ZERO, S_SU,  PC_MID};
         6'd31: i = '{OP_ADD,  S_ZERO, S_ZERO, S_SP, PC_MID};
         6'd32: i = '{OP_JMP,  S_ZERO, S_ZERO, S_X,  PC_COMMON};
         // insulated
         6'd33: i = '{OP_ADD,  S_ZERO, S_ZERO, S_SU, PC_MID};
         6'd34: i = '{OP_ADD,  S_ZERO, S_ZERO, S_SP, PC_MID};
         6'd35: i = '{OP_JMP,  S_ZERO, S_ZERO, S_X,  PC_COMMON};
         // convection
         6'd36: i = '{OP_ADD,  S_H,   S_H,    S_T,   PC_MID};
         6'd37: i = '{OP_MUL,  S_T,   S_DX,   S_T,   PC_MID};
         6'd38: i = '{OP_DIV,  S_T,   S_KP,   S_T,   PC_MID};
         6'd39: i = '{OP_ADD,  S_ONE, S_T,    S_T,   PC_MID};
         6'd40: i = '{OP_DIV,  S_H,   S_T,    S_T,   PC_MID};
         6'd41: i = '{OP_MUL,  S_T,   S_V,    S_SU,  PC_MID};
         6'd42: i = '{OP_NEG,  S_T,   S_ZERO, S_SP,  PC_MID};
         // diagonal and rhs
         6'd43: i = '{OP_ADD,  S_AP0, S_A,    S_D,   PC_MID};
         6'd44: i = '{OP_SUB,  S_D,   S_SP,   S_D,   PC_MID};
         6'd45: i = '{OP_MUL,  S_AP0, S_U0,   S_R,   PC_MID};
         6'd46: i = '{OP_ADD,  S_SU,  S_R,    S_R,   PC_MID};
         6'd47: i = '{OP_SIDE, S_ZERO, S_ZERO, S_X,  PC_MID};
         6'd48: i = '{OP_ADD,  S_ZERO, S_ZERO, S_L,  PC_MID};
         6'd49: i = '{OP_NEG,  S_A,   S_ZERO, S_U,   PC_MID};
         6'd50: i = '{OP_JMP,  S_ZERO, S_ZERO, S_X,  PC_RESID};
         6'd51: i = '{OP_ADD,  S_ZERO, S_ZERO, S_U,  PC_MID};
         6'd52: i = '{OP_NEG,  S_A,   S_ZERO, S_L,   PC_MID};
         // residual
         6'd53: i = '{OP_MUL,  S_D,   S_UP,   S_X,   PC_MID};
         6'd54: i = '{OP_MUL,  S_OFF, S_UN,   S_ACC, PC_MID};
         6'd55: i = '{OP_ADD,  S_X,   S_ACC,  S_ACC, PC_MID};
         6'd56: i = '{OP_SUB,  S_R,   S_ACC,  S_RES, PC_MID};
         6'd57: i = '{OP_END,  S_ZERO, S_ZERO, S_X,  PC_MID};
         default: i = '{OP_END, S_ZERO, S_ZERO, S_X, PC_MID};
      endcase
      return i;
   endfunction

endpackage

/* sv/fv_heat_row_assembler.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Implicit 1-D finite-volume heat row assembler. Cells arrive left to right on
// req_*; each cell after the first yields the tridiagonal row of the previous
// cell on rsp_*, and the req_tlast cell, if not the first, yields a second row, its
// own right-boundary row. A small microcoded sequencer drives one saturating
// adder, one 32x32 multiplier and one restoring divider that produces one
// quotient bit per cycle. The divider sets the pace of row assembly, and a
// first cell yields no row and, unless flagged req_tlast, only fills the
// window. req_tready is low while a row is assembled; a finished row waits in
// the output register.
module fv_heat_row_assembler #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: density[30:0], heat_capacity[61:31], conductivity[92:62],
   //            old_temp[124:93], cur_temp[156:125], zero pad [159:157]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,
   input  logic         req_tlast,
   // rsp_tdata: lower[31:0], diag[63:32], upper[95:64], rhs[127:96],
   //            residual[159:128]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,
   // rsp_tuser: saturated
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

   // Control
   fv_heat_pkg::state_type state_ff, state_in;
   fv_heat_pkg::row_type   row_ff, row_in;
   logic [5:0]  pc_ff, pc_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  cs_ff, cs_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        sat_ff, sat_in;
   logic        harm_ff, harm_in;
   logic        neg_ff, neg_in;

   // Configuration
   logic [30:0] cell_width_ff, cell_width_in;
   logic [30:0] time_step_ff, time_step_in;
   logic [1:0]  left_kind_ff, left_kind_in;
   logic [31:0] left_value_ff, left_value_in;
   logic [30:0] left_coeff_ff, left_coeff_in;
   logic [1:0]  right_kind_ff, right_kind_in;
   logic [31:0] right_value_ff, right_value_in;
   logic [30:0] right_coeff_ff, right_coeff_in;

   // Cell window
   logic [30:0] wc0_ff, wc0_in, wc1_ff, wc1_in;
   logic [31:0] wt0_ff, wt0_in, wt1_ff, wt1_in;
   logic [30:0] mid_rho_ff, mid_rho_in, mid_cp_ff, mid_cp_in;
   logic [31:0] mid_u0_ff, mid_u0_in;

   // Latched request
   logic [30:0] in_rho_ff, in_rho_in, in_cp_ff, in_cp_in, in_k_ff, in_k_in;
   logic [31:0] in_u0_ff, in_u0_in, in_uc_ff, in_uc_in;
   logic        in_last_ff, in_last_in;

   // Temporaries
   logic [31:0] x_ff, x_in, ap0_ff, ap0_in, a_ff, a_in, ae_ff, ae_in;
   logic [31:0] t_ff, t_in, su_ff, su_in, sp_ff, sp_in, d_ff, d_in;
   logic [31:0] l_ff, l_in, u_ff, u_in, r_ff, r_in, acc_ff, acc_in;
   logic [31:0] res_ff, res_in;

   // Arithmetic unit state
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [31:0] rem_ff, rem_in;

   // Output register
   logic [159:0] rsp_data_ff, rsp_data_in;
   logic         rsp_user_ff, rsp_user_in;
   logic         rsp_last_ff, rsp_last_in;

   fv_heat_pkg::instr_type ins;
   logic signed [31:0] a_val, b_val;
   logic signed [32:0] alu_s;
   logic        alu_sat;
   logic [31:0] alu_val;
   logic signed [63:0] mul_p;
   logic [63:0] prod_mag;
   logic [31:0] a_mag, b_mag;
   logic [31:0] harm_sum;
   logic [32:0] rem_sh;
   logic        div_ge;
   logic        mag_sat;
   logic [31:0] mag_val;
   logic        wr_en;
   logic [31:0] wr_val;
   logic        is_left, is_right;
   logic [1:0]  cur_kind;
   logic        req_fire;

   assign ins      = fv_heat_pkg::ucode(pc_ff);
   assign is_left  = (row_ff == fv_heat_pkg::ROW_LEFT);
   assign is_right = (row_ff == fv_heat_pkg::ROW_RIGHT);
   assign cur_kind = is_left ? left_kind_ff : right_kind_ff;
   assign req_fire = req_tvalid && req_tready;

   assign req_tready = (state_ff == fv_heat_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Operand selection; the row kind decides which cell plays which role
   function automatic logic [31:0] pick(input fv_heat_pkg::src_type s);
      logic [31:0] v;
      v = '0;
      case (s)
         fv_heat_pkg::S_ZERO: v = '0;
         fv_heat_pkg::S_ONE:  v = ONE_Q;
         fv_heat_pkg::S_RHO:  v = {1'b0, is_right ? in_rho_ff : mid_rho_ff};
         fv_heat_pkg::S_CP:   v = {1'b0, is_right ? in_cp_ff : mid_cp_ff};
         fv_heat_pkg::S_KW:   v = {1'b0, wc0_ff};
         fv_heat_pkg::S_KP:   v = {1'b0, is_right ? in_k_ff : wc1_ff};
         fv_heat_pkg::S_KO:   v = {1'b0, is_right ? wc1_ff : in_k_ff};
         fv_heat_pkg::S_U0:   v = is_right ? in_u0_ff : mid_u0_ff;
         fv_heat_pkg::S_UW:   v = wt0_ff;
         fv_heat_pkg::S_UP:   v = is_right ? in_uc_ff : wt1_ff;
         fv_heat_pkg::S_UN:   v = is_right ? wt1_ff : in_uc_ff;
         fv_heat_pkg::S_DX:   v = {1'b0, cell_width_ff};
         fv_heat_pkg::S_DT:   v = {1'b0, time_step_ff};
         fv_heat_pkg::S_V:    v = is_left ? left_value_ff : right_value_ff;
         fv_heat_pkg::S_H:    v = {1'b0, is_left ? left_coeff_ff : right_coeff_ff};
         fv_heat_pkg::S_X:    v = x_ff;
         fv_heat_pkg::S_AP0:  v = ap0_ff;
         fv_heat_pkg::S_A:    v = a_ff;
         fv_heat_pkg::S_AE:   v = ae_ff;
         fv_heat_pkg::S_T:    v = t_ff;
         fv_heat_pkg::S_SU:   v = su_ff;
         fv_heat_pkg::S_SP:   v = sp_ff;
         fv_heat_pkg::S_D:    v = d_ff;
         fv_heat_pkg::S_L:    v = l_ff;
         fv_heat_pkg::S_U:    v = u_ff;
         fv_heat_pkg::S_R:    v = r_ff;
         fv_heat_pkg::S_ACC:  v = acc_ff;
         fv_heat_pkg::S_RES:  v = res_ff;
         fv_heat_pkg::S_OFF:  v = is_left ? u_ff : l_ff;
         default:             v = '0;
      endcase
      return v;
   endfunction

   // Shared arithmetic: saturating add, product, divider step
   always_comb begin
      a_val = $signed(pick(ins.sa));
      b_val = $signed(pick(ins.sb));

      case (ins.op)
         fv_heat_pkg::OP_SUB: alu_s = {a_val[31], a_val} - {b_val[31], b_val};
         fv_heat_pkg::OP_NEG: alu_s = 33'sd0 - {a_val[31], a_val};
         default:             alu_s = {a_val[31], a_val} + {b_val[31], b_val};
      endcase
      alu_sat = alu_s[32] ^ alu_s[31];
      alu_val = alu_sat ? (alu_s[32] ? fv_heat_pkg::Q_MIN : fv_heat_pkg::Q_MAX)
                        : alu_s[31:0];

      mul_p    = 64'(a_val) * 64'(b_val);
      prod_mag = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
      a_mag    = a_val[31] ? 32'(-a_val) : 32'(a_val);
      b_mag    = b_val[31] ? 32'(-b_val) : 32'(b_val);
      harm_sum = 32'(a_val) + 32'(b_val);

      rem_sh = {rem_ff, dvd_ff[63]};
      div_ge = (rem_sh >= {1'b0, dsr_ff});

      // Magnitude to signed Q with saturation
      if (neg_ff) begin
         mag_sat = (|dvd_ff[63:32]) || (dvd_ff[31] && (|dvd_ff[30:0]));
         mag_val = mag_sat ? fv_heat_pkg::Q_MIN : 32'(-dvd_ff[31:0]);
      end else begin
         mag_sat = |dvd_ff[63:31];
         mag_val = mag_sat ? fv_heat_pkg::Q_MAX : dvd_ff[31:0];
      end
   end

   // Sequencer and next-state logic
   always_comb begin
      state_in = state_ff;   row_in = row_ff;     pc_in = pc_ff;
      cnt_in = cnt_ff;       cs_in = cs_ff;       rsp_valid_in = rsp_valid_ff;
      sat_in = sat_ff;       harm_in = harm_ff;   neg_in = neg_ff;
      cell_width_in = cell_width_ff;   time_step_in = time_step_ff;
      left_kind_in = left_kind_ff;     left_value_in = left_value_ff;
      left_coeff_in = left_coeff_ff;   right_kind_in = right_kind_ff;
      right_value_in = right_value_ff; right_coeff_in = right_coeff_ff;
      wc0_in = wc0_ff; wc1_in = wc1_ff; wt0_in = wt0_ff; wt1_in = wt1_ff;
      mid_rho_in = mid_rho_ff; mid_cp_in = mid_cp_ff; mid_u0_in = mid_u0_ff;
      in_rho_in = in_rho_ff; in_cp_in = in_cp_ff; in_k_in = in_k_ff;
      in_u0_in = in_u0_ff;   in_uc_in = in_uc_ff; in_last_in = in_last_ff;
      x_in = x_ff; ap0_in = ap0_ff; a_in = a_ff; ae_in = ae_ff; t_in = t_ff;
      su_in = su_ff; sp_in = sp_ff; d_in = d_ff; l_in = l_ff; u_in = u_ff;
      r_in = r_ff; acc_in = acc_ff; res_in = res_ff;
      prod_in = prod_ff; dvd_in = dvd_ff; dsr_in = dsr_ff; rem_in = rem_ff;
      rsp_data_in = rsp_data_ff; rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      wr_en  = 1'b0;
      wr_val = '0;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            fv_heat_pkg::CSR_CELL_WIDTH:  cell_width_in  = csr_data[30:0];
            fv_heat_pkg::CSR_TIME_STEP:   time_step_in   = csr_data[30:0];
            fv_heat_pkg::CSR_LEFT_KIND:   left_kind_in   = csr_data[1:0];
            fv_heat_pkg::CSR_LEFT_VALUE:  left_value_in  = csr_data;
            fv_heat_pkg::CSR_LEFT_COEFF:  left_coeff_in  = csr_data[30:0];
            fv_heat_pkg::CSR_RIGHT_KIND:  right_kind_in  = csr_data[1:0];
            fv_heat_pkg::CSR_RIGHT_VALUE: right_value_in = csr_data;
            fv_heat_pkg::CSR_RIGHT_COEFF: right_coeff_in = csr_data[30:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         fv_heat_pkg::ST_IDLE: begin
            if (req_fire) begin
               in_rho_in  = req_tdata[30:0];
               in_cp_in   = req_tdata[61:31];
               in_k_in    = req_tdata[92:62];
               in_u0_in   = req_tdata[124:93];
               in_uc_in   = req_tdata[156:125];
               in_last_in = req_tlast;
               sat_in     = 1'b0;
               if (cs_ff == fv_heat_pkg::CS_START) begin
                  // first cell yields no row; unless it is also the last, it fills the window
                  if (!req_tlast) begin
                     wc1_in     = req_tdata[92:62];
                     wt1_in     = req_tdata[156:125];
                     mid_rho_in = req_tdata[30:0];
                     mid_cp_in  = req_tdata[61:31];
                     mid_u0_in  = req_tdata[124:93];
                     cs_in      = fv_heat_pkg::CS_FIRST;
                  end
               end else if (cs_ff == fv_heat_pkg::CS_FIRST) begin
                  row_in   = fv_heat_pkg::ROW_LEFT;
                  pc_in    = fv_heat_pkg::PC_EDGE;
                  state_in = fv_heat_pkg::ST_EXEC;
               end else begin
                  row_in   = fv_heat_pkg::ROW_MID;
                  pc_in    = fv_heat_pkg::PC_MID;
                  state_in = fv_heat_pkg::ST_EXEC;
               end
            end
         end

         fv_heat_pkg::ST_EXEC: begin
            pc_in = pc_ff + 6'd1;
            case (ins.op)
               fv_heat_pkg::OP_ADD, fv_heat_pkg::OP_SUB, fv_heat_pkg::OP_NEG: begin
                  wr_en  = 1'b1;
                  wr_val = alu_val;
                  sat_in = sat_ff | alu_sat;
               end
               fv_heat_pkg::OP_MUL: begin
                  prod_in  = mul_p;
                  pc_in    = pc_ff;
                  state_in = fv_heat_pkg::ST_MUL;
               end
               fv_heat_pkg::OP_DIV: begin
                  if (b_val == 32'sd0) begin
                     // divide by zero: saturate toward the dividend's sign
                     wr_en  = 1'b1;
                     wr_val = a_val[31] ? fv_heat_pkg::Q_MIN
                            : ((a_val != 32'sd0) ? fv_heat_pkg::Q_MAX : '0);
                     sat_in = 1'b1;
                  end else begin
                     dvd_in   = 64'(a_mag) << FRAC_BITS;
                     dsr_in   = b_mag;
                     rem_in   = '0;
                     cnt_in   = '1;
                     neg_in   = a_val[31] ^ b_val[31];
                     harm_in  = 1'b0;
                     pc_in    = pc_ff;
                     state_in = fv_heat_pkg::ST_DIV;
                  end
               end
               fv_heat_pkg::OP_HARM: begin
                  if (harm_sum == '0) begin
                     wr_en  = 1'b1;
                     wr_val = '0;
                  end else begin
                     prod_in  = mul_p;
                     dsr_in   = harm_sum;
                     pc_in    = pc_ff;
                     state_in = fv_heat_pkg::ST_HARM;
                  end
               end
               fv_heat_pkg::OP_JMP: pc_in = ins.tgt;
               fv_heat_pkg::OP_KIND: begin
                  case (cur_kind)
                     fv_heat_pkg::KIND_TEMP: pc_in = fv_heat_pkg::PC_K_TEMP;
                     fv_heat_pkg::KIND_FLUX: pc_in = fv_heat_pkg::PC_K_FLUX;
                     fv_heat_pkg::KIND_CONV: pc_in = fv_heat_pkg::PC_K_CONV;
                     default:                pc_in = fv_heat_pkg::PC_K_NONE;
                  endcase
               end
               fv_heat_pkg::OP_SIDE:
                  pc_in = is_left ? fv_heat_pkg::PC_LEFT : fv_heat_pkg::PC_RIGHT;
               default: begin
                  pc_in    = pc_ff;
                  state_in = fv_heat_pkg::ST_EMIT;
               end
            endcase
         end

         // product scaled back to Q, truncated toward zero
         fv_heat_pkg::ST_MUL: begin
            neg_in   = prod_ff[63];
            dvd_in   = prod_mag >> FRAC_BITS;
            harm_in  = 1'b0;
            state_in = fv_heat_pkg::ST_WB;
         end

         // harmonic mean: 2*ka*kb over ka+kb
         fv_heat_pkg::ST_HARM: begin
            dvd_in   = {prod_ff[62:0], 1'b0};
            rem_in   = '0;
            cnt_in   = '1;
            neg_in   = 1'b0;
            harm_in  = 1'b1;
            state_in = fv_heat_pkg::ST_DIV;
         end

         // one quotient bit per cycle
         fv_heat_pkg::ST_DIV: begin
            rem_in = div_ge ? 32'(rem_sh - {1'b0, dsr_ff}) : rem_sh[31:0];
            dvd_in = {dvd_ff[62:0], div_ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = fv_heat_pkg::ST_WB;
            end
         end

         fv_heat_pkg::ST_WB: begin
            wr_en    = 1'b1;
            wr_val   = harm_ff ? dvd_ff[31:0] : mag_val;
            sat_in   = sat_ff | (!harm_ff && mag_sat);
            pc_in    = pc_ff + 6'd1;
            state_in = fv_heat_pkg::ST_EXEC;
         end

         fv_heat_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_ff, r_ff, u_ff, d_ff, l_ff};
               rsp_user_in  = sat_ff;
               rsp_last_in  = is_right;
               if (!is_right && in_last_ff) begin
                  row_in   = fv_heat_pkg::ROW_RIGHT;
                  pc_in    = fv_heat_pkg::PC_EDGE;
                  sat_in   = 1'b0;
                  state_in = fv_heat_pkg::ST_EXEC;
               end else begin
                  // slide the window
                  wc0_in     = wc1_ff;
                  wc1_in     = in_k_ff;
                  wt0_in     = wt1_ff;
                  wt1_in     = in_uc_ff;
                  mid_rho_in = in_rho_ff;
                  mid_cp_in  = in_cp_ff;
                  mid_u0_in  = in_u0_ff;
                  cs_in      = in_last_ff ? fv_heat_pkg::CS_START
                                          : fv_heat_pkg::CS_INNER;
                  state_in   = fv_heat_pkg::ST_IDLE;
               end
            end
         end

         default: state_in = fv_heat_pkg::ST_IDLE;
      endcase

      // Result write-back
      if (wr_en) begin
         case (ins.dst)
            fv_heat_pkg::S_X:   x_in   = wr_val;
            fv_heat_pkg::S_AP0: ap0_in = wr_val;
            fv_heat_pkg::S_A:   a_in   = wr_val;
            fv_heat_pkg::S_AE:  ae_in  = wr_val;
            fv_heat_pkg::S_T:   t_in   = wr_val;
            fv_heat_pkg::S_SU:  su_in  = wr_val;
            fv_heat_pkg::S_SP:  sp_in  = wr_val;
            fv_heat_pkg::S_D:   d_in   = wr_val;
            fv_heat_pkg::S_L:   l_in   = wr_val;
            fv_heat_pkg::S_U:   u_in   = wr_val;
            fv_heat_pkg::S_R:   r_in   = wr_val;
            fv_heat_pkg::S_ACC: acc_in = wr_val;
            fv_heat_pkg::S_RES: res_in = wr_val;
            default: ;
         endcase
      end
   end

   // Control, configuration and window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fv_heat_pkg::ST_IDLE;
         row_ff         <= fv_heat_pkg::ROW_MID;
         pc_ff          <= fv_heat_pkg::PC_MID;
         cnt_ff         <= '0;
         cs_ff          <= fv_heat_pkg::CS_START;
         rsp_valid_ff   <= 1'b0;
         sat_ff         <= 1'b0;
         harm_ff        <= 1'b0;
         neg_ff         <= 1'b0;
         cell_width_ff  <= ONE_Q[30:0];
         time_step_ff   <= ONE_Q[30:0];
         left_kind_ff   <= fv_heat_pkg::KIND_TEMP;
         left_value_ff  <= '0;
         left_coeff_ff  <= '0;
         right_kind_ff  <= fv_heat_pkg::KIND_TEMP;
         right_value_ff <= '0;
         right_coeff_ff <= '0;
         wc0_ff         <= '0;
         wc1_ff         <= '0;
         wt0_ff         <= '0;
         wt1_ff         <= '0;
         mid_rho_ff     <= '0;
         mid_cp_ff      <= '0;
         mid_u0_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         row_ff         <= row_in;
         pc_ff          <= pc_in;
         cnt_ff         <= cnt_in;
         cs_ff          <= cs_in;
         rsp_valid_ff   <= rsp_valid_in;
         sat_ff         <= sat_in;
         harm_ff        <= harm_in;
         neg_ff         <= neg_in;
         cell_width_ff  <= cell_width_in;
         time_step_ff   <= time_step_in;
         left_kind_ff   <= left_kind_in;
         left_value_ff  <= left_value_in;
         left_coeff_ff  <= left_coeff_in;
         right_kind_ff  <= right_kind_in;
         right_value_ff <= right_value_in;
         right_coeff_ff <= right_coeff_in;
         wc0_ff         <= wc0_in;
         wc1_ff         <= wc1_in;
         wt0_ff         <= wt0_in;
         wt1_ff         <= wt1_in;
         mid_rho_ff     <= mid_rho_in;
         mid_cp_ff      <= mid_cp_in;
         mid_u0_ff      <= mid_u0_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      in_rho_ff   <= in_rho_in;
      in_cp_ff    <= in_cp_in;
      in_k_ff     <= in_k_in;
      in_u0_ff    <= in_u0_in;
      in_uc_ff    <= in_uc_in;
      in_last_ff  <= in_last_in;
      x_ff        <= x_in;
      ap0_ff      <= ap0_in;
      a_ff        <= a_in;
      ae_ff       <= ae_in;
      t_ff        <= t_in;
      su_ff       <= su_in;
      sp_ff       <= sp_in;
      d_ff        <= d_in;
      l_ff        <= l_in;
      u_ff        <= u_in;
      r_ff        <= r_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      prod_ff     <= prod_in;
      dvd_ff      <= dvd_in;
      dsr_ff      <= dsr_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Checks
   `ASSERT_ALWAYS(a_cs_code, clock, reset, cs_ff != fv_heat_pkg::CS_SPARE)
   `ASSERT_NEXT(a_div_runs, clock, reset, (state_ff == fv_heat_pkg::ST_DIV) && (cnt_ff != '0), state_ff == fv_heat_pkg::ST_DIV)
   `ASSERT_NEXT(a_busy_on_row, clock, reset, req_fire && (cs_ff != fv_heat_pkg::CS_START), !req_tready)
   `ASSERT_ALWAYS(a_pc_span, clock, reset, (state_ff == fv_heat_pkg::ST_IDLE) || (pc_ff <= fv_heat_pkg::PC_LAST))

endmodule

/* bench/fv_heat_row_assembler_test.sv */
`timescale 1ns / 1ps

module fv_heat_row_assembler_test;

   // one tridiagonal row as seen on rsp_*
   typedef struct packed {
      logic signed [31:0] lower;
      logic signed [31:0] diag;
      logic signed [31:0] upper;
      logic signed [31:0] rhs;
      logic signed [31:0] residual;
      logic               saturated;
      logic               last_row;
   } heat_row_type;

   // row predictor and queue of pending rows
   class row_scoreboard;
      logic [30:0] dx, dt, hl, hr;
      logic [1:0]  kl, kr;
      logic signed [31:0] vl, vr;
      logic signed [31:0] kwin [2];
      logic signed [31:0] uwin [2];
      logic signed [31:0] m_rho, m_cp, m_u0;
      logic [1:0] pos;
      bit sat;
      heat_row_type pending [$];
      int errors;

      function void clear();
         dx = 31'h10000; dt = 31'h10000;
         kl = fv_heat_pkg::KIND_TEMP; kr = fv_heat_pkg::KIND_TEMP;
         vl = 0; vr = 0; hl = 0; hr = 0;
         kwin[0] = 0; kwin[1] = 0; uwin[0] = 0; uwin[1] = 0;
         m_rho = 0; m_cp = 0; m_u0 = 0;
         pos = fv_heat_pkg::CS_START;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            fv_heat_pkg::CSR_CELL_WIDTH:  dx = val[30:0];
            fv_heat_pkg::CSR_TIME_STEP:   dt = val[30:0];
            fv_heat_pkg::CSR_LEFT_KIND:   kl = val[1:0];
            fv_heat_pkg::CSR_LEFT_VALUE:  vl = val;
            fv_heat_pkg::CSR_LEFT_COEFF:  hl = val[30:0];
            fv_heat_pkg::CSR_RIGHT_KIND:  kr = val[1:0];
            fv_heat_pkg::CSR_RIGHT_VALUE: vr = val;
            fv_heat_pkg::CSR_RIGHT_COEFF: hr = val[30:0];
            default: ;
         endcase
      endfunction

      function logic signed [31:0] clamp(logic signed [63:0] v);
         if (v > 64'sh7FFF_FFFF) begin
            sat = 1;
            return fv_heat_pkg::Q_MAX;
         end
         if (v < -64'sh8000_0000) begin
            sat = 1;
            return fv_heat_pkg::Q_MIN;
         end
         return v[31:0];
      endfunction

      function logic signed [31:0] add(logic signed [31:0] a, logic signed [31:0] b);
         return clamp(64'(a) + 64'(b));
      endfunction

      function logic signed [31:0] sub(logic signed [31:0] a, logic signed [31:0] b);
         return clamp(64'(a) - 64'(b));
      endfunction

      function logic signed [31:0] neg(logic signed [31:0] a);
         return clamp(-64'(a));
      endfunction

      function logic signed [31:0] mul(logic signed [31:0] a, logic signed [31:0] b);
         logic signed [63:0] p;
         logic signed [63:0] q;
         p = 64'(a) * 64'(b);
         if (p >= 0) q = p >>> 16;
         else q = -((-p) >>> 16);
         return clamp(q);
      endfunction

      function logic signed [31:0] div(logic signed [31:0] a, logic signed [31:0] b);
         logic signed [63:0] n;
         if (b == 0) begin
            sat = 1;
            return a > 0 ? fv_heat_pkg::Q_MAX : (a < 0 ? fv_heat_pkg::Q_MIN : 32'sd0);
         end
         n = 64'(a) <<< 16;
         return clamp(n / 64'(b));
      endfunction

      // harmonic mean of two conductivities, exact quotient
      function logic signed [31:0] hmean(logic signed [31:0] a, logic signed [31:0] b);
         logic [64:0] s;
         logic [95:0] p;
         s = 65'(a[31:0]) + 65'(b[31:0]);
         if (s == 0) return 0;
         p = 96'(a[31:0]) * 96'(b[31:0]) * 2;
         return 32'(p / s);
      endfunction

      function logic signed [31:0] storage(logic signed [31:0] rho, logic signed [31:0] cp);
         return div(mul(mul(rho, cp), $signed({1'b0, dx})), $signed({1'b0, dt}));
      endfunction

      function heat_row_type edge_row(bit left, logic signed [31:0] rho, logic signed [31:0] cp,
            logic signed [31:0] kp, logic signed [31:0] kf, logic signed [31:0] u0,
            logic signed [31:0] up, logic signed [31:0] un);
         heat_row_type w;
         logic [1:0] kind;
         logic signed [31:0] v, h, d, ap0, a, su, sp, t;
         d = $signed({1'b0, dx});
         kind = left ? kl : kr;
         v = left ? vl : vr;
         h = left ? $signed({1'b0, hl}) : $signed({1'b0, hr});
         ap0 = storage(rho, cp);
         a = div(kf, d);
         su = 0; sp = 0;
         case (kind)
            fv_heat_pkg::KIND_TEMP: begin
               t = div(add(kp, kp), d);
               su = mul(t, v);
               sp = neg(t);
            end
            fv_heat_pkg::KIND_FLUX: su = neg(v);
            fv_heat_pkg::KIND_CONV: begin
               t = div(mul(add(h, h), d), kp);
               t = add(32'sh10000, t);
               t = div(h, t);
               su = mul(t, v);
               sp = neg(t);
            end
            default: ;
         endcase
         w.diag = sub(add(ap0, a), sp);
         w.rhs = add(su, mul(ap0, u0));
         if (left) begin
            w.lower = 0;
            w.upper = neg(a);
            w.residual = sub(w.rhs, add(mul(w.diag, up), mul(w.upper, un)));
         end else begin
            w.upper = 0;
            w.lower = neg(a);
            w.residual = sub(w.rhs, add(mul(w.lower, un), mul(w.diag, up)));
         end
         return w;
      endfunction

      // accepted cell: queue the rows it releases
      function void note_cell(logic [30:0] rho_i, logic [30:0] cp_i, logic [30:0] k_i,
            logic signed [31:0] u0, logic signed [31:0] uc, bit last);
         heat_row_type w;
         logic signed [31:0] rho, cp, k, d, ap0, aw, ae;
         rho = {1'b0, rho_i}; cp = {1'b0, cp_i}; k = {1'b0, k_i};
         if (pos == fv_heat_pkg::CS_START) begin
            if (!last) begin
               kwin[1] = k; uwin[1] = uc;
               m_rho = rho; m_cp = cp; m_u0 = u0;
               pos = fv_heat_pkg::CS_FIRST;
            end
            return;
         end
         sat = 0;
         if (pos == fv_heat_pkg::CS_FIRST) begin
            w = edge_row(1, m_rho, m_cp, kwin[1], hmean(kwin[1], k), m_u0, uwin[1], uc);
         end else begin
            d = $signed({1'b0, dx});
            ap0 = storage(m_rho, m_cp);
            aw = div(hmean(kwin[0], kwin[1]), d);
            ae = div(hmean(kwin[1], k), d);
            w.lower = neg(aw);
            w.diag = add(add(ap0, aw), ae);
            w.upper = neg(ae);
            w.rhs = mul(ap0, m_u0);
            w.residual = sub(w.rhs, add(add(mul(w.lower, uwin[0]),
                                            mul(w.diag, uwin[1])), mul(w.upper, uc)));
         end
         w.saturated = sat;
         w.last_row = 0;
         pending.push_back(w);
         if (last) begin
            sat = 0;
            w = edge_row(0, rho, cp, k, hmean(k, kwin[1]), u0, uc, uwin[1]);
            w.saturated = sat;
            w.last_row = 1;
            pending.push_back(w);
            pos = fv_heat_pkg::CS_START;
         end else begin
            pos = fv_heat_pkg::CS_INNER;
         end
         kwin[0] = kwin[1]; kwin[1] = k;
         uwin[0] = uwin[1]; uwin[1] = uc;
         m_rho = rho; m_cp = cp; m_u0 = u0;
      endfunction

      function void check_row(heat_row_type got);
         heat_row_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected row: diag %h", got.diag);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("row mismatch: exp l %h d %h u %h r %h res %h s %b t %b",
                  want.lower, want.diag, want.upper, want.rhs, want.residual,
                  want.saturated, want.last_row,
                  " / got l %h d %h u %h r %h res %h s %b t %b",
                  got.lower, got.diag, got.upper,
                  got.rhs, got.residual, got.saturated, got.last_row);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [159:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   row_scoreboard rows = new();
   bit steady;   // no idling on either side
   bit done;

   fv_heat_row_assembler i_dut (.*);

   always #1 clock = ~clock;

   // result side: random stall, check each accepted row
   always @(posedge clock) begin
      heat_row_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.lower = rsp_tdata[31:0];
         got.diag = rsp_tdata[63:32];
         got.upper = rsp_tdata[95:64];
         got.rhs = rsp_tdata[127:96];
         got.residual = rsp_tdata[159:128];
         got.saturated = rsp_tuser;
         got.last_row = rsp_tlast;
         rows.check_row(got);
      end
      rsp_tready <= steady || ($urandom_range(99) >= 36);
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      rows.write_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // valid stays up after an accept; the next call reuses or drops it, drain() drops it
   task automatic send_cell(logic [30:0] rho, logic [30:0] cp, logic [30:0] k,
         logic [31:0] u0, logic [31:0] uc, bit last);
      if (!steady && $urandom_range(99) < 36) begin
         req_tvalid <= 0;
         do @(posedge clock); while (!steady && $urandom_range(99) < 36);
      end
      req_tvalid <= 1;
      req_tdata <= {3'b0, uc, u0, k, cp, rho};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rows.note_cell(rho, cp, k, u0, uc, last);
   endtask

   // let all rows drain, plus the first-cell slack, before touching registers
   task automatic drain();
      req_tvalid <= 0;
      while (rows.pending.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   function automatic logic [30:0] rnd31();
      case ($urandom_range(5))
         0: return 31'h7FFF_FFFF;
         1: return 31'($urandom_range(1));
         2: return 31'($urandom);
         default: return 31'($urandom_range(32'h0004_0000, 32'h0000_4000));
      endcase
   endfunction

   function automatic logic [31:0] rnd32();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return $urandom;
         default: return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
      endcase
   endfunction

   task automatic random_mesh(int cells);
      logic [30:0] k;
      for (int i = 0; i < cells; i++) begin
         k = rnd31();
         if (k == 0) k = 1;
         send_cell(rnd31(), rnd31(), k, rnd32(), rnd32(), i == cells - 1);
      end
   endtask

   task automatic random_regs();
      logic [31:0] v;
      v = 32'(rnd31()); write_csr(fv_heat_pkg::CSR_CELL_WIDTH, v == 0 ? 32'h1 : v);
      v = 32'(rnd31()); write_csr(fv_heat_pkg::CSR_TIME_STEP, v == 0 ? 32'h1 : v);
      write_csr(fv_heat_pkg::CSR_LEFT_KIND, $urandom_range(3));
      write_csr(fv_heat_pkg::CSR_LEFT_VALUE, rnd32());
      write_csr(fv_heat_pkg::CSR_LEFT_COEFF, 32'(rnd31()));
      write_csr(fv_heat_pkg::CSR_RIGHT_KIND, $urandom_range(3));
      write_csr(fv_heat_pkg::CSR_RIGHT_VALUE, rnd32());
      write_csr(fv_heat_pkg::CSR_RIGHT_COEFF, 32'(rnd31()));
   endtask

   initial begin
      int sent;
      rows.clear();
      steady = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: lone cell, two-cell mesh, extremes, every boundary kind
      send_cell(31'h10000, 31'h10000, 31'h10000, 32'h10000, 32'h10000, 1);
      send_cell(31'h10000, 31'h20000, 31'h10000, 32'h10000, 32'h20000, 0);
      send_cell(31'h10000, 31'h10000, 31'h30000, 32'h30000, 32'h0, 1);
      send_cell(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 0);
      send_cell(31'h0, 31'h0, 31'h1, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_cell(31'h7FFF_FFFF, 31'h1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 1);
      for (int kk = 0; kk < 4; kk++) begin
         drain();
         write_csr(fv_heat_pkg::CSR_LEFT_KIND, kk);
         write_csr(fv_heat_pkg::CSR_RIGHT_KIND, 3 - kk);
         write_csr(fv_heat_pkg::CSR_LEFT_VALUE, kk[0] ? 32'h8000_0000 : 32'h0003_0000);
         write_csr(fv_heat_pkg::CSR_RIGHT_VALUE, kk[1] ? 32'h7FFF_FFFF : 32'hFFFE_0000);
         write_csr(fv_heat_pkg::CSR_LEFT_COEFF, kk == 1 ? 32'h7FFF_FFFF : 32'h0002_0000);
         write_csr(fv_heat_pkg::CSR_RIGHT_COEFF, kk == 3 ? 32'h0 : 32'h0000_8000);
         write_csr(fv_heat_pkg::CSR_CELL_WIDTH,
                   kk == 2 ? 32'h7FFF_FFFF : 32'h1 << (14 + kk));
         write_csr(fv_heat_pkg::CSR_TIME_STEP, kk == 3 ? 32'h1 : 32'h0002_0000);
         send_cell(31'h20000, 31'h8000, 31'h18000, 32'h50000, 32'h40000, 0);
         send_cell(31'h10000, 31'h10000, 31'h7FFF_FFFF, 32'hFFF0_0000, 32'h10000, 0);
         send_cell(31'h30000, 31'h4000, 31'h1, 32'h20000, 32'hFFFF_0000, 1);
      end

      // random meshes, registers sometimes changed between them
      sent = 0;
      while (sent < 2000) begin
         int cells;
         steady = (sent >= 800 && sent < 1000);
         if ($urandom_range(3) == 0) begin
            drain();
            random_regs();
         end
         cells = $urandom_range(9) == 0 ? 1 : $urandom_range(12, 2);
         random_mesh(cells);
         sent += cells;
      end
      drain();
      done = 1;
   end

   initial begin
      wait (done);
      if (rows.errors == 0 && rows.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/fv_heat_pkg.sv
sv/fv_heat_row_assembler.sv
bench/fv_heat_row_assembler_test.sv
